// ===== rtl/core/par_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// par_pkg
// Shared types and constants of the primitive assembly rewriter.
// ----------------------------------------------------------------------------
package par_pkg;

  localparam int unsigned VERTEX_BITS = 32;
  localparam int unsigned IN_BITS     = 32;
  localparam int unsigned OUT_BITS    = 32;
  localparam int unsigned MAX_RES     = 8;
  localparam int unsigned SLOT_W      = $clog2(MAX_RES);
  localparam int unsigned CNT_W       = $clog2(MAX_RES + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [3:0] {
    PRIM_POINTS     = 4'd0,
    PRIM_LINES      = 4'd1,
    PRIM_LINE_STRIP = 4'd2,
    PRIM_LINE_LOOP  = 4'd3,
    PRIM_TRIS       = 4'd4,
    PRIM_TRI_STRIP  = 4'd5,
    PRIM_TRI_FAN    = 4'd6,
    PRIM_QUADS      = 4'd7,
    PRIM_QUAD_STRIP = 4'd8,
    PRIM_POLYGON    = 4'd9
  } prim_mode_e;

  typedef enum logic [1:0] {
    POLY_POINT = 2'd0,
    POLY_LINE  = 2'd1,
    POLY_FILL  = 2'd2
  } poly_mode_e;

  typedef enum logic [1:0] {
    TOPO_POINTS = 2'd0,
    TOPO_LINES  = 2'd1,
    TOPO_TRIS   = 2'd2
  } topo_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIM_MODE      = 2'd0,
    CFG_POLY_MODE      = 2'd1,
    CFG_LAST_PROVOKING = 2'd2,
    CFG_FLAT_SHADING   = 2'd3
  } cfg_reg_e;

  typedef logic [VERTEX_BITS-1:0] vtx_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    vtx_t [MAX_RES-1:0] list;
    logic [CNT_W-1:0]   cnt;
    logic [1:0]         topo;
  } prim_entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/par_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// par_front
// Holds the configuration and batch state, classifies each vertex beat and
// builds the explicit index list it causes.
// ----------------------------------------------------------------------------
module par_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire  par_pkg::cfg_wr_t      cfg_i,
  input  wire  [par_pkg::IN_BITS-1:0] vertex_index_i,
  input  wire                         end_of_batch_i,
  input  wire                         accept_i,
  output par_pkg::prim_entry_t        entry_o,
  output logic                        push_o
);
  import par_pkg::*;

  logic [3:0] prim_mode_q;
  logic [1:0] poly_mode_q;
  logic       last_prov_q;
  logic       flat_q;

  vtx_t       first_q;
  vtx_t       hist_q [3];
  logic [1:0] seen_q;
  logic [1:0] phase_q;
  logic [1:0] phase_d;

  vtx_t               v, h0, h1, h2, fv;
  logic               odd, lp, fill;
  vtx_t [MAX_RES-1:0] list_d;
  logic [CNT_W-1:0]   cnt_d;
  logic [1:0]         topo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_mode_q <= PRIM_POINTS;
      poly_mode_q <= POLY_FILL;
      last_prov_q <= 1'b0;
      flat_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PRIM_MODE:      prim_mode_q <= cfg_i.data[3:0];
        CFG_POLY_MODE:      poly_mode_q <= cfg_i.data[1:0];
        CFG_LAST_PROVOKING: last_prov_q <= cfg_i.data[0];
        CFG_FLAT_SHADING:   flat_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign v    = vertex_index_i[VERTEX_BITS-1:0];
  assign h0   = hist_q[0];
  assign h1   = hist_q[1];
  assign h2   = hist_q[2];
  assign fv   = (seen_q == 2'd0) ? v : first_q;
  assign odd  = phase_q[0];
  assign lp   = last_prov_q;
  assign fill = (poly_mode_q != POLY_POINT) && (poly_mode_q != POLY_LINE);

  always_comb begin
    if (prim_mode_q == PRIM_POINTS) begin
      topo_d = TOPO_POINTS;
    end else if (prim_mode_q <= PRIM_LINE_LOOP) begin
      topo_d = TOPO_LINES;
    end else if (prim_mode_q <= PRIM_TRI_FAN) begin
      topo_d = TOPO_TRIS;
    end else if (prim_mode_q <= PRIM_POLYGON) begin
      if (poly_mode_q == POLY_POINT)     topo_d = TOPO_POINTS;
      else if (poly_mode_q == POLY_LINE) topo_d = TOPO_LINES;
      else                               topo_d = TOPO_TRIS;
    end else begin
      topo_d = TOPO_POINTS;
    end
  end

  always_comb begin
    list_d = '0;
    cnt_d  = '0;
    unique case (prim_mode_q)
      PRIM_POINTS: begin
        list_d[0] = v;
        cnt_d     = CNT_W'(1);
      end
      PRIM_LINES: begin
        if (odd) begin
          list_d[0] = lp ? v : h0;
          list_d[1] = lp ? h0 : v;
          cnt_d     = CNT_W'(2);
        end
      end
      PRIM_LINE_STRIP, PRIM_LINE_LOOP: begin
        if (seen_q != 2'd0) begin
          list_d[0] = lp ? v : h0;
          list_d[1] = lp ? h0 : v;
          cnt_d     = CNT_W'(2);
        end
      end
      PRIM_TRIS: begin
        if (phase_q == 2'd2) begin
          list_d[0] = lp ? v : h1;
          list_d[1] = lp ? h1 : h0;
          list_d[2] = lp ? h0 : v;
          cnt_d     = CNT_W'(3);
        end
      end
      PRIM_TRI_STRIP: begin
        if (seen_q >= 2'd2) begin
          if (odd) begin
            list_d[0] = lp ? v : h1;
            list_d[1] = lp ? h0 : v;
            list_d[2] = lp ? h1 : h0;
          end else begin
            list_d[0] = lp ? v : h1;
            list_d[1] = lp ? h1 : h0;
            list_d[2] = lp ? h0 : v;
          end
          cnt_d = CNT_W'(3);
        end
      end
      PRIM_TRI_FAN: begin
        if (seen_q >= 2'd2) begin
          list_d[0] = lp ? v : h0;
          list_d[1] = lp ? fv : v;
          list_d[2] = lp ? h0 : fv;
          cnt_d     = CNT_W'(3);
        end
      end
      PRIM_QUADS: begin
        if (poly_mode_q == POLY_POINT) begin
          list_d[0] = v;
          cnt_d     = CNT_W'(1);
        end else if (phase_q == 2'd3) begin
          if (!fill) begin
            list_d[0] = h2; list_d[1] = h1;
            list_d[2] = h1; list_d[3] = h0;
            list_d[4] = h0; list_d[5] = v;
            list_d[6] = v;  list_d[7] = h2;
            cnt_d     = CNT_W'(8);
          end else if (flat_q) begin
            list_d[0] = v; list_d[1] = h2; list_d[2] = h1;
            list_d[3] = v; list_d[4] = h1; list_d[5] = h0;
            cnt_d     = CNT_W'(6);
          end else begin
            list_d[0] = h2; list_d[1] = h1; list_d[2] = h0;
            list_d[3] = h2; list_d[4] = h0; list_d[5] = v;
            cnt_d     = CNT_W'(6);
          end
        end
      end
      PRIM_QUAD_STRIP: begin
        if (poly_mode_q == POLY_POINT) begin
          list_d[0] = v;
          cnt_d     = CNT_W'(1);
        end else if (seen_q == 2'd3 && odd) begin
          if (!fill) begin
            list_d[0] = h2; list_d[1] = h1;
            list_d[2] = h1; list_d[3] = v;
            list_d[4] = v;  list_d[5] = h0;
            list_d[6] = h0; list_d[7] = h2;
            cnt_d     = CNT_W'(8);
          end else if (flat_q) begin
            list_d[0] = v; list_d[1] = h0; list_d[2] = h2;
            list_d[3] = v; list_d[4] = h2; list_d[5] = h1;
            cnt_d     = CNT_W'(6);
          end else begin
            list_d[0] = h2; list_d[1] = h1; list_d[2] = h0;
            list_d[3] = h0; list_d[4] = h1; list_d[5] = v;
            cnt_d     = CNT_W'(6);
          end
        end
      end
      PRIM_POLYGON: begin
        if (poly_mode_q == POLY_POINT) begin
          list_d[0] = v;
          cnt_d     = CNT_W'(1);
        end else if (!fill) begin
          if (seen_q != 2'd0) begin
            list_d[0] = h0;
            list_d[1] = v;
            cnt_d     = CNT_W'(2);
          end
        end else if (seen_q >= 2'd2) begin
          list_d[0] = fv;
          list_d[1] = h0;
          list_d[2] = v;
          cnt_d     = CNT_W'(3);
        end
      end
      default: ;
    endcase

    // close the loop or outline after the last vertex's own edge
    if (end_of_batch_i && seen_q != 2'd0) begin
      if (prim_mode_q == PRIM_LINE_LOOP ||
          (prim_mode_q == PRIM_POLYGON && poly_mode_q == POLY_LINE)) begin
        if (cnt_d == '0) begin
          list_d[0] = (prim_mode_q == PRIM_LINE_LOOP && lp) ? fv : v;
          list_d[1] = (prim_mode_q == PRIM_LINE_LOOP && lp) ? v : fv;
          cnt_d     = CNT_W'(2);
        end else begin
          list_d[2] = (prim_mode_q == PRIM_LINE_LOOP && lp) ? fv : v;
          list_d[3] = (prim_mode_q == PRIM_LINE_LOOP && lp) ? v : fv;
          cnt_d     = CNT_W'(4);
        end
      end
    end
  end

  always_comb begin
    if (prim_mode_q == PRIM_TRIS) begin
      phase_d = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
    end else begin
      phase_d = phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= '0;
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
      seen_q    <= '0;
      phase_q   <= '0;
    end else if (accept_i) begin
      if (end_of_batch_i) begin
        first_q   <= '0;
        hist_q[0] <= '0;
        hist_q[1] <= '0;
        hist_q[2] <= '0;
        seen_q    <= '0;
        phase_q   <= '0;
      end else begin
        if (seen_q == 2'd0) begin
          first_q <= v;
        end
        hist_q[2] <= h1;
        hist_q[1] <= h0;
        hist_q[0] <= v;
        if (seen_q != 2'd3) begin
          seen_q <= seen_q + 2'd1;
        end
        phase_q <= phase_d;
      end
    end
  end

  assign entry_o.list = list_d;
  assign entry_o.cnt  = cnt_d;
  assign entry_o.topo = topo_d;
  assign push_o       = accept_i && (cnt_d != '0);

endmodule
`default_nettype wire

// ===== rtl/core/par_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// par_queue
// Short queue of built primitive lists between front and back.
// ----------------------------------------------------------------------------
module par_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire par_pkg::prim_entry_t push_data_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  valid_o,
  output par_pkg::prim_entry_t  pop_data_o
);
  import par_pkg::*;

  prim_entry_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/par_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// par_back
// Takes one built list at a time from the queue and sends it out one
// index beat per cycle while out_ready_i holds, marking each list's last beat.
// ----------------------------------------------------------------------------
module par_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          q_valid_i,
  input  wire  par_pkg::prim_entry_t   q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [par_pkg::OUT_BITS-1:0] out_index_o,
  output logic [1:0]                   topology_o,
  output logic                         last_of_run_o
);
  import par_pkg::*;

  logic                busy_q;
  vtx_t [MAX_RES-1:0]  list_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [1:0]          topo_q;
  logic [SLOT_W-1:0]   pos_q;
  logic                beat_done, last_beat;

  assign last_beat     = (CNT_W'(pos_q) + CNT_W'(1) == cnt_q);
  assign beat_done     = busy_q && out_ready_i;
  assign q_pop_o       = q_valid_i && (!busy_q || (beat_done && last_beat));
  assign out_valid_o   = busy_q;
  assign out_index_o   = OUT_BITS'(list_q[pos_q]);
  assign topology_o    = topo_q;
  assign last_of_run_o = last_beat;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      list_q <= q_data_i.list;
      cnt_q  <= q_data_i.cnt;
      topo_q <= q_data_i.topo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
    end else if (beat_done) begin
      if (last_beat) begin
        busy_q <= 1'b0;
        pos_q  <= '0;
      end else begin
        pos_q <= pos_q + SLOT_W'(1);
      end
    end
  end

  a_pos_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (CNT_W'(pos_q) < cnt_q))
    else $error("beat position beyond list length");

  a_no_empty_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("empty list loaded");

  a_mid_list_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_done && !last_beat) |=> busy_q)
    else $error("list dropped before its last beat");

  a_idle_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && !busy_q) |=> busy_q)
    else $error("queued list not taken while idle");

endmodule
`default_nettype wire

// ===== rtl/core/primitive_assembly_rewriter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// primitive_assembly_rewriter
// Turns a stream of vertex indices into explicit point, line or triangle
// index lists, with provoking-vertex rotation and loop closing.
// ----------------------------------------------------------------------------
// A vertex beat is taken in every cycle while the two-entry list queue has
// room; each vertex causes zero to eight output index beats, and the output
// port sends one index per cycle while out_ready_i is high. A list's first
// index leaves via the queue, then the back's list register. Configuration
// writes are always ready; the user must make them only while the block
// is drained, which the block itself does not enforce.
module primitive_assembly_rewriter (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [par_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [par_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [par_pkg::IN_BITS-1:0]        vertex_index_i,
  input  wire                                end_of_batch_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [par_pkg::OUT_BITS-1:0]       out_index_o,
  output logic [1:0]                         topology_o,
  output logic                               last_of_run_o
);
  import par_pkg::*;

  cfg_wr_t     cfg_wr;
  prim_entry_t front_entry, q_entry;
  logic        push, q_full, q_valid, q_pop;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;
  assign in_ready_o   = !q_full;

  par_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_wr),
    .vertex_index_i (vertex_index_i),
    .end_of_batch_i (end_of_batch_i),
    .accept_i       (in_valid_i && in_ready_o),
    .entry_o        (front_entry),
    .push_o         (push)
  );

  par_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_entry)
  );

  par_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_index_o   (out_index_o),
    .topology_o    (topology_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire
